### hdl/cdar_pkg.sv
`default_nettype none

package cdar_pkg;

    localparam int MAX_PACKET_BYTES = 512;

    localparam int ADDR_W = $clog2(MAX_PACKET_BYTES);
    localparam int CNT_W  = $clog2(MAX_PACKET_BYTES + 1);
    // name walk offsets can run up to one length byte past the buffer
    localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 512);

    localparam int HDR_LEN  = 12;
    localparam int TAIL_LEN = 16;

    localparam logic [7:0] FLAGS_HI   = 8'h81;
    localparam logic [7:0] FLAGS_LO   = 8'h80;
    localparam logic [7:0] PTR_MARK   = 8'hC0;
    localparam logic [7:0] PTR_OFFSET = 8'h0C;
    localparam logic [7:0] TTL_SECS   = 8'h3C;
    localparam logic [7:0] RDATA_LEN  = 8'h04;
    localparam logic [7:0] ONE_BYTE   = 8'h01;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } cdar_in_t;

    typedef struct packed {
        logic [63:0] resp_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } cdar_out_t;

    // one response byte handed from the byte sequencer to the word packer
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic [2:0] lane;
        logic       word_end;
        logic       resp_end;
    } cdar_byte_t;

endpackage

`default_nettype wire

### hdl/cdar_packer.sv
`default_nettype none

module cdar_packer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cdar_pkg::cdar_byte_t lane_byte,
    output logic                     busy,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output cdar_pkg::cdar_out_t      out_data
);
    import cdar_pkg::*;

    logic [7:0][7:0] acc_reg;
    logic [7:0][7:0] acc_next;
    cdar_out_t       pend_reg;
    cdar_out_t       pend_next;
    cdar_out_t       out_reg;
    cdar_out_t       out_next;
    cdar_out_t       done_word;
    logic            full_reg;
    logic            full_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            take;
    logic            done;

    assign take      = !out_valid_reg || !out_stall;
    assign busy      = full_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (lane_byte.valid)
        begin
            // first byte of a word clears the unused tail
            if (lane_byte.lane == 3'd0)
            begin
                acc_next = '0;
            end
            acc_next[~lane_byte.lane] = lane_byte.data;
        end

        done = lane_byte.valid && lane_byte.word_end;
        done_word.resp_word   = acc_next;
        done_word.valid_bytes = {1'b0, lane_byte.lane} + 4'd1;
        done_word.last_word   = lane_byte.resp_end;

        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        full_next      = full_reg;
        pend_next      = pend_reg;

        if (full_reg && take)
        begin
            out_next       = pend_reg;
            out_valid_next = 1'b1;
            full_next      = 1'b0;
        end

        if (done)
        begin
            if (take && !full_reg)
            begin
                out_next       = done_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                pend_next = done_word;
                full_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    a_no_byte_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        lane_byte.valid |-> !full_reg)
        else $error("response byte arrived while a finished word was pending");

    a_short_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.last_word |-> out_reg.valid_bytes == 4'd8)
        else $error("partial word emitted before the end of a response");

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |-> out_valid_reg)
        else $error("pending word held while the output register was empty");

endmodule

`default_nettype wire

### hdl/captive_dns_a_responder_top.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// in       into       in_valid / in_stall    in_data  (data_byte, last_byte)
// out      out of     out_valid / out_stall  out_data (resp_word, valid_bytes, last_word)
// cfg      into       cfg_we                 cfg_data (answer address)
//
// Query bytes are taken one per cycle while in_stall is low. After the last byte the
// block checks the header, walks the first name (each length byte is read from the
// store, then evaluated), checks lengths, waits for a free packer, then gathers words.
// in_stall is high from the last byte until the response is packed or the query dropped.
// Reset clears control state and the answer address; the packet store needs none.
// A stalled output holds one word in the packer and one pending; the next waits.

module captive_dns_a_responder_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire cdar_pkg::cdar_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output cdar_pkg::cdar_out_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_data
);
    import cdar_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_CHECK   = 7'b0000010,
        ST_WALK_RD = 7'b0000100,
        ST_WALK_EV = 7'b0001000,
        ST_FIN     = 7'b0010000,
        ST_GATHER  = 7'b0100000,
        ST_WAIT    = 7'b1000000
    } state_t;

    logic [7:0] mem [MAX_PACKET_BYTES];

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] nend_reg, nend_next;
    logic [POS_W-1:0] rlen_reg, rlen_next;
    logic [POS_W-1:0] tail_reg, tail_next;
    logic [POS_W-1:0] rb_reg, rb_next;
    logic [POS_W-1:0] s1_idx_reg, s1_idx_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_wend_reg, s1_wend_next;
    logic             s1_rend_reg, s1_rend_next;
    logic [31:0]      ip_reg;
    logic [7:0]       id_hi_reg, id_lo_reg, qd_hi_reg, qd_lo_reg;
    logic [3:0]       opcode_reg;
    logic [7:0]       rd_q;
    logic [ADDR_W-1:0] rd_addr;
    logic             accept, room, wr_en;
    logic [POS_W-1:0] len_ext, tail_off;
    logic             rb_last;
    logic [7:0]       sel_byte;
    logic             pk_busy;
    cdar_byte_t       lane_byte;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign room     = count_reg < CNT_W'(MAX_PACKET_BYTES);
    assign wr_en    = accept && room;
    assign len_ext  = POS_W'(len_reg);
    assign rb_last  = (rb_reg + POS_W'(1)) == rlen_reg;
    assign rd_addr  = (state_reg == ST_WALK_RD) ? pos_reg[ADDR_W-1:0] : rb_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[ADDR_W-1:0]] <= in_data.data_byte;
        end
        rd_q <= mem[rd_addr];
    end

    // header fields are snooped on the way into the store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (count_reg == CNT_W'(0)) id_hi_reg  <= in_data.data_byte;
            if (count_reg == CNT_W'(1)) id_lo_reg  <= in_data.data_byte;
            if (count_reg == CNT_W'(2)) opcode_reg <= in_data.data_byte[6:3];
            if (count_reg == CNT_W'(4)) qd_hi_reg  <= in_data.data_byte;
            if (count_reg == CNT_W'(5)) qd_lo_reg  <= in_data.data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg <= '0;
        end
        else if (cfg_we)
        begin
            ip_reg <= cfg_data;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        nend_next     = nend_reg;
        rlen_next     = rlen_reg;
        tail_next     = tail_reg;
        rb_next       = rb_reg;
        s1_valid_next = 1'b0;
        s1_idx_next   = s1_idx_reg;
        s1_wend_next  = s1_wend_reg;
        s1_rend_next  = s1_rend_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.last_byte)
                    begin
                        len_next   = room ? count_reg + CNT_W'(1) : count_reg;
                        count_next = '0;
                        state_next = ST_CHECK;
                    end
                    else if (room)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_CHECK:
            begin
                if (len_reg < CNT_W'(HDR_LEN) || opcode_reg != 4'd0 ||
                    {qd_hi_reg, qd_lo_reg} == 16'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next   = POS_W'(HDR_LEN);
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD:
            begin
                // drop the packet once the walk leaves it
                state_next = (pos_reg >= len_ext) ? ST_IDLE : ST_WALK_EV;
            end
            ST_WALK_EV:
            begin
                if (rd_q == 8'd0)
                begin
                    nend_next  = pos_reg + POS_W'(1);
                    state_next = ST_FIN;
                end
                else if ((rd_q & PTR_MARK) == PTR_MARK)
                begin
                    nend_next  = pos_reg + POS_W'(2);
                    state_next = ST_FIN;
                end
                else
                begin
                    pos_next   = pos_reg + POS_W'(1) + POS_W'(rd_q);
                    state_next = ST_WALK_RD;
                end
            end
            ST_FIN:
            begin
                if (nend_reg + POS_W'(4) > len_ext ||
                    nend_reg + POS_W'(4 + TAIL_LEN) > POS_W'(MAX_PACKET_BYTES))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    // the last word of the previous response may still be pending
                    rlen_next  = nend_reg + POS_W'(4 + TAIL_LEN);
                    tail_next  = nend_reg + POS_W'(4);
                    rb_next    = '0;
                    state_next = ST_WAIT;
                end
            end
            ST_GATHER:
            begin
                s1_valid_next = 1'b1;
                s1_idx_next   = rb_reg;
                s1_wend_next  = (rb_reg[2:0] == 3'd7) || rb_last;
                s1_rend_next  = rb_last;
                rb_next       = rb_reg + POS_W'(1);
                if ((rb_reg[2:0] == 3'd7) || rb_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // hold until the word's last byte is packed and the packer has room
                if (!s1_valid_reg)
                begin
                    if (rb_reg == rlen_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!pk_busy)
                    begin
                        state_next = ST_GATHER;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        pos_reg     <= pos_next;
        nend_reg    <= nend_next;
        rlen_reg    <= rlen_next;
        tail_reg    <= tail_next;
        rb_reg      <= rb_next;
        s1_idx_reg  <= s1_idx_next;
        s1_wend_reg <= s1_wend_next;
        s1_rend_reg <= s1_rend_next;
    end

    assign tail_off = s1_idx_reg - tail_reg;

    always_comb
    begin
        sel_byte = rd_q;
        if (s1_idx_reg < POS_W'(HDR_LEN))
        begin
            case (s1_idx_reg[3:0])
                4'd0:    sel_byte = id_hi_reg;
                4'd1:    sel_byte = id_lo_reg;
                4'd2:    sel_byte = FLAGS_HI;
                4'd3:    sel_byte = FLAGS_LO;
                4'd5:    sel_byte = ONE_BYTE;
                4'd7:    sel_byte = ONE_BYTE;
                default: sel_byte = 8'd0;
            endcase
        end
        else if (s1_idx_reg >= tail_reg)
        begin
            case (tail_off[3:0])
                4'd0:    sel_byte = PTR_MARK;
                4'd1:    sel_byte = PTR_OFFSET;
                4'd3:    sel_byte = ONE_BYTE;
                4'd5:    sel_byte = ONE_BYTE;
                4'd9:    sel_byte = TTL_SECS;
                4'd11:   sel_byte = RDATA_LEN;
                4'd12:   sel_byte = ip_reg[31:24];
                4'd13:   sel_byte = ip_reg[23:16];
                4'd14:   sel_byte = ip_reg[15:8];
                4'd15:   sel_byte = ip_reg[7:0];
                default: sel_byte = 8'd0;
            endcase
        end
    end

    assign lane_byte.valid    = s1_valid_reg;
    assign lane_byte.data     = sel_byte;
    assign lane_byte.lane     = s1_idx_reg[2:0];
    assign lane_byte.word_end = s1_wend_reg;
    assign lane_byte.resp_end = s1_rend_reg;

    cdar_packer u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_byte (lane_byte),
        .busy      (pk_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    a_read_from_gather: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(state_reg == ST_GATHER))
        else $error("response byte issued outside the gather state");

    a_gather_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GATHER |-> rb_reg < rlen_reg)
        else $error("response byte index ran past the response length");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register is not one-hot");

endmodule

`default_nettype wire

### tb/sv/tb_captive_dns_a_responder_top.sv
`timescale 1ns / 1ps

module tb_captive_dns_a_responder_top;
    import cdar_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int IDLE_WAIT   = 1200;
    localparam int HOLD_CYCLES = 600;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    cdar_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    cdar_out_t   out_data;
    logic        cfg_we;
    logic [31:0] cfg_data;

    // predicted block state
    logic [7:0]  pkt_mem [MAX_PACKET_BYTES];
    int          pkt_len;
    logic [31:0] answer_ip;
    cdar_out_t   reply_q[$];
    int          reply_words;

    int err_cnt      = 0;
    int cycle_cnt    = 0;
    int words_seen   = 0;
    int tx_gap_max   = 0;
    int burst_left   = 0;
    int rx_stall_max = 0;
    int rx_run_left  = 0;
    int hold_left    = 0;
    bit hold_req     = 1'b0;

    captive_dns_a_responder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout with %0d response words outstanding", reply_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        if (err_cnt < 100)
            $display("mismatch: %s", msg);
        err_cnt++;
    endtask

    // Build the answer for a finished query and queue its words.
    function automatic void emit_reply(input int len);
        int           pos;
        int           qname_stop;
        int           qlen;
        int           rlen;
        logic [95:0]  head;
        logic [127:0] tail;
        logic [7:0]   rbuf [MAX_PACKET_BYTES];
        cdar_out_t    w;

        if (len < HDR_LEN || pkt_mem[2][6:3] != 4'd0)
            return;
        if (pkt_mem[4] == 8'd0 && pkt_mem[5] == 8'd0)
            return;

        pos = HDR_LEN;
        qname_stop = -1;
        while (qname_stop < 0 && pos < len)
        begin
            if (pkt_mem[pos] == 8'd0)
                qname_stop = pos + 1;
            else if (pkt_mem[pos] >= PTR_MARK)
                qname_stop = pos + 2;
            else
                pos = pos + 1 + int'(pkt_mem[pos]);
        end
        if (qname_stop < 0 || qname_stop + 4 > len)
            return;

        qlen = qname_stop + 4 - HDR_LEN;
        rlen = HDR_LEN + qlen + TAIL_LEN;
        if (rlen > MAX_PACKET_BYTES)
            return;

        head = {pkt_mem[0], pkt_mem[1], FLAGS_HI, FLAGS_LO,
                8'h00, ONE_BYTE, 8'h00, ONE_BYTE, 32'h0};
        tail = {PTR_MARK, PTR_OFFSET, 8'h00, ONE_BYTE, 8'h00, ONE_BYTE,
                24'h0, TTL_SECS, 8'h00, RDATA_LEN, answer_ip};
        for (int i = 0; i < rlen; i++)
        begin
            if (i < HDR_LEN)
                rbuf[i] = head[95 - 8 * i -: 8];
            else if (i < HDR_LEN + qlen)
                rbuf[i] = pkt_mem[i];
            else
                rbuf[i] = tail[127 - 8 * (i - HDR_LEN - qlen) -: 8];
        end

        for (int k = 0; k < rlen; k += 8)
        begin
            w.resp_word = '0;
            for (int j = 0; j < 8; j++)
                w.resp_word = {w.resp_word[55:0], (k + j < rlen) ? rbuf[k + j] : 8'h00};
            w.valid_bytes = (rlen - k > 8) ? 4'd8 : 4'(rlen - k);
            w.last_word = (k + 8 >= rlen);
            reply_q.push_back(w);
            reply_words++;
        end
    endfunction

    task automatic take_byte(input logic [7:0] b, input logic l);
        // drop bytes past the store, as the receive buffer does
        if (pkt_len < MAX_PACKET_BYTES)
        begin
            pkt_mem[pkt_len] = b;
            pkt_len++;
        end
        if (l)
        begin
            emit_reply(pkt_len);
            pkt_len = 0;
        end
    endtask

    // Sender pacing: bursts of random length separated by random gaps.
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 16);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic l);
        in_data <= '{data_byte: b, last_byte: l};
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        take_byte(b, l);
        pace();
    endtask

    task automatic send_packet(input byte_q_t q);
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        // hold until a rejected query has surely finished its name walk
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_ip(input logic [31:0] ip);
        settle();
        cfg_data <= ip;
        cfg_we <= 1'b1;
        @(posedge clk);
        answer_ip = ip;
        cfg_we <= 1'b0;
    endtask

    task automatic put_random(inout byte_q_t q, input int n);
        repeat (n) q.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_header(inout byte_q_t q, input logic [15:0] id,
                              input logic [7:0] f_hi, input logic [7:0] f_lo,
                              input logic [15:0] qd);
        q.push_back(id[15:8]);
        q.push_back(id[7:0]);
        q.push_back(f_hi);
        q.push_back(f_lo);
        q.push_back(qd[15:8]);
        q.push_back(qd[7:0]);
        put_random(q, 6);
    endtask

    // Append a name of about total bytes, ended by a zero or by a pointer.
    task automatic put_name(inout byte_q_t q, input int total, input int max_label,
                            input bit ptr_end);
        int left;
        int upper;
        int lab;
        left = ptr_end ? total - 2 : total - 1;
        if (left == 1)
            left = 2;
        while (left > 0)
        begin
            upper = (left - 1 < max_label) ? left - 1 : max_label;
            lab = $urandom_range(1, upper);
            if (left - lab - 1 == 1)
                lab++;
            q.push_back(8'(lab));
            put_random(q, lab);
            left = left - lab - 1;
        end
        if (ptr_end)
        begin
            q.push_back(PTR_MARK | 8'($urandom_range(63)));
            put_random(q, 1);
        end
        else
            q.push_back(8'h00);
    endtask

    task automatic random_query(output byte_q_t q);
        int          kind;
        int          cut;
        logic [7:0]  f_hi;
        logic [15:0] qd;
        kind = $urandom_range(99);
        q.delete();
        if (kind >= 88)
        begin
            put_random(q, $urandom_range(1, 40));
            return;
        end
        f_hi = 8'($urandom_range(255));
        f_hi[6:3] = 4'd0;
        qd = 16'($urandom_range(1, 65535));
        if (kind >= 80)
        begin
            if ($urandom_range(1) == 1)
                f_hi[6:3] = 4'($urandom_range(1, 15));
            else
                qd = 16'd0;
        end
        put_header(q, 16'($urandom_range(65535)), f_hi, 8'($urandom_range(255)), qd);
        put_name(q, ($urandom_range(3) == 0) ? 1 : $urandom_range(3, 30),
                 $urandom_range(1, 12), $urandom_range(9) == 0);
        put_random(q, 4 + (($urandom_range(3) == 0) ? $urandom_range(1, 8) : 0));
        // cut a well-formed query short
        if (kind >= 70 && kind < 80)
        begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut)
                void'(q.pop_back());
        end
    endtask

    // Receiver: stall runs of its own, plus one long hold on request.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (rx_stall_max == 0)
            out_stall <= 1'b0;
        else if (rx_run_left > 0)
            rx_run_left--;
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            rx_run_left = $urandom_range(0, 3 * rx_stall_max);
        end
        else
        begin
            out_stall <= 1'b1;
            rx_run_left = $urandom_range(0, rx_stall_max - 1);
        end
    end

    always @(posedge clk)
    begin : check_words
        cdar_out_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (reply_q.size() == 0)
                flag_error($sformatf("word %0d not expected: %h", words_seen,
                                     out_data.resp_word));
            else
            begin
                want = reply_q.pop_front();
                if (out_data.resp_word !== want.resp_word)
                    flag_error($sformatf("word %0d resp_word %h, expected %h", words_seen,
                                         out_data.resp_word, want.resp_word));
                if (out_data.valid_bytes !== want.valid_bytes)
                    flag_error($sformatf("word %0d valid_bytes %0d, expected %0d",
                                         words_seen, out_data.valid_bytes,
                                         want.valid_bytes));
                if (out_data.last_word !== want.last_word)
                    flag_error($sformatf("word %0d last_word %b, expected %b", words_seen,
                                         out_data.last_word, want.last_word));
            end
            words_seen++;
        end
    end

    task automatic test_basic_answers();
        byte_q_t q;
        write_ip(32'h0000_0000);
        // root name, zero ID and flag bytes
        q.delete();
        put_header(q, 16'h0000, 8'h00, 8'h00, 16'h0001);
        put_name(q, 1, 63, 1'b0);
        put_random(q, 4);
        send_packet(q);
        write_ip(32'hFFFF_FFFF);
        // all flag bits outside the opcode set
        q.delete();
        put_header(q, 16'hFFFF, 8'h87, 8'hFF, 16'hFFFF);
        put_name(q, 5, 3, 1'b0);
        put_random(q, 4);
        send_packet(q);
        // question count nonzero in its high byte only
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0100);
        put_name(q, 12, 8, 1'b0);
        put_random(q, 4);
        send_packet(q);
    endtask

    task automatic test_rejected_queries();
        byte_q_t q;
        q.delete();
        put_random(q, 1);
        send_packet(q);
        q.delete();
        put_random(q, 11);
        send_packet(q);
        // header only: the name walk starts at the end
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        send_packet(q);
        for (int b = 3; b <= 6; b++)
        begin
            q.delete();
            put_header(q, 16'($urandom), 8'(1 << b), 8'h00, 16'h0001);
            put_name(q, 6, 4, 1'b0);
            put_random(q, 4);
            send_packet(q);
        end
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0000);
        put_name(q, 6, 4, 1'b0);
        put_random(q, 4);
        send_packet(q);
        // label runs past the end of the packet
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        q.push_back(8'h20);
        put_random(q, 5);
        send_packet(q);
        // name fits but type and class are one byte short
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        put_name(q, 4, 2, 1'b0);
        put_random(q, 3);
        send_packet(q);
        // pointer mark as the final byte
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        q.push_back(8'hC5);
        send_packet(q);
    endtask

    task automatic test_name_forms();
        byte_q_t q;
        write_ip(32'($urandom));
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        q.push_back(PTR_MARK);
        q.push_back(PTR_OFFSET);
        put_random(q, 4);
        send_packet(q);
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        put_name(q, 6, 3, 1'b1);
        put_random(q, 4);
        send_packet(q);
        // lengths between 0x40 and 0xBF are skipped like plain labels
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        q.push_back(8'h45);
        put_random(q, 8'h45);
        q.push_back(8'h00);
        put_random(q, 7);
        send_packet(q);
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        q.push_back(8'hBF);
        put_random(q, 8'hBF);
        q.push_back(8'h00);
        put_random(q, 4);
        send_packet(q);
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        q.push_back(8'hFF);
        q.push_back(8'h00);
        put_random(q, 4);
        send_packet(q);
        // extra records after the question are not copied
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0002);
        put_name(q, 10, 4, 1'b0);
        put_random(q, 11);
        send_packet(q);
    endtask

    task automatic test_truncation();
        byte_q_t q;
        write_ip(32'($urandom));
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        put_name(q, 9, 4, 1'b0);
        put_random(q, 520 - q.size());
        send_packet(q);
        // name ends beyond the stored bytes
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        put_name(q, 560, 63, 1'b0);
        put_random(q, 4);
        send_packet(q);
        // the count must restart after an overlong packet
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        put_name(q, 7, 5, 1'b0);
        put_random(q, 4);
        send_packet(q);
    endtask

    task automatic test_reply_size_limit();
        byte_q_t q;
        write_ip(32'($urandom));
        // response of exactly the maximum size, then one byte over
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        put_name(q, MAX_PACKET_BYTES - HDR_LEN - TAIL_LEN - 4, 63, 1'b0);
        put_random(q, 4);
        send_packet(q);
        q.delete();
        put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
        put_name(q, MAX_PACKET_BYTES - HDR_LEN - TAIL_LEN - 3, 63, 1'b0);
        put_random(q, 4);
        send_packet(q);
    endtask

    task automatic test_output_hold();
        byte_q_t q;
        write_ip(32'($urandom));
        tx_gap_max = 0;
        rx_stall_max = 0;
        hold_req = 1'b1;
        repeat (3)
        begin
            q.delete();
            put_header(q, 16'($urandom), 8'h01, 8'h00, 16'h0001);
            put_name(q, $urandom_range(3, 20), 6, 1'b0);
            put_random(q, 4);
            send_packet(q);
        end
    endtask

    task automatic test_random_traffic(input int n_bytes, input int min_words,
                                       input int gap, input int stall);
        byte_q_t q;
        int      sent;
        int      words0;
        tx_gap_max = gap;
        rx_stall_max = stall;
        sent = 0;
        words0 = reply_words;
        while (sent < n_bytes || reply_words - words0 < min_words)
        begin
            random_query(q);
            send_packet(q);
            sent += q.size();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        pkt_len = 0;
        answer_ip = '0;
        reply_words = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gap_max = 2;
        rx_stall_max = 3;
        test_basic_answers();
        test_rejected_queries();
        test_name_forms();
        test_truncation();
        test_reply_size_limit();
        test_output_hold();

        write_ip(32'h0A00_0001);
        test_random_traffic(110, 12, 0, 0);
        write_ip(32'($urandom));
        test_random_traffic(110, 12, 3, 2);
        write_ip(32'hC0A8_0401);
        test_random_traffic(110, 12, 8, 6);
        write_ip(32'($urandom));
        test_random_traffic(110, 12, 1, 12);

        settle();
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
hdl/cdar_pkg.sv
hdl/cdar_packer.sv
hdl/captive_dns_a_responder_top.sv
tb/sv/tb_captive_dns_a_responder_top.sv
